FILE: rtl/lamt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamt_pkg
// Shared types, codes and default sizes of the local address match table.
// ----------------------------------------------------------------------------
package lamt_pkg;

  localparam int TABLE_ENTRIES_DEF   = 64;
  localparam int LINKS_PER_ENTRY_DEF = 4;
  localparam int LOGICAL_IFCS_DEF    = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND  = 2'd1;
  localparam logic [1:0] STATUS_TABLE_FULL = 2'd2;
  localparam logic [1:0] STATUS_LINKS_FULL = 2'd3;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_UNICAST = 2'd1;

  localparam logic [15:0] REFS_MAX  = 16'hFFFF;
  localparam logic [63:0] NULL_V4LO = 64'h0000_FFFF_0000_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [1:0]  kind;
    logic [3:0]  owner;
    logic        owner_ok;
    logic        null_addr;
  } work_t;

  typedef struct packed {
    logic [3:0]  owner;
    logic [15:0] refs;
  } slot_t;

endpackage

FILE: rtl/lamt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamt_if
// Request and result channels of the local address match table.
// ----------------------------------------------------------------------------
interface lamt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [1:0]  entry_kind;
  logic [3:0]  lifc_id;

  modport source (output valid, command, addr_high, addr_low, entry_kind, lifc_id,
                  input ready);
  modport sink (input valid, command, addr_high, addr_low, entry_kind, lifc_id,
                output ready);
endinterface

interface lamt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] match_kind;
  logic       link_added;
  logic       link_dropped;
  logic       entry_dropped;

  modport source (output valid, status, match_kind, link_added, link_dropped,
                  entry_dropped, input ready);
  modport sink (input valid, status, match_kind, link_added, link_dropped,
                entry_dropped, output ready);
endinterface

FILE: rtl/lamt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamt_front
// Accepts request beats, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module lamt_front #(
  parameter int LOGICAL_IFCS = lamt_pkg::LOGICAL_IFCS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  lamt_in_if.sink         in,
  output lamt_pkg::work_t q_item,
  output logic            q_valid,
  input  logic            q_pop
);

  lamt_pkg::work_t w;
  lamt_pkg::work_t buf_q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  always_comb begin
    w.cmd       = in.command;
    w.hi        = in.addr_high;
    w.lo        = in.addr_low;
    w.kind      = (in.entry_kind == lamt_pkg::KIND_NONE) ? lamt_pkg::KIND_UNICAST
                                                         : in.entry_kind;
    w.owner     = in.lifc_id;
    w.owner_ok  = int'(in.lifc_id) < LOGICAL_IFCS;
    w.null_addr = (in.addr_high == 64'd0) &&
                  ((in.addr_low == 64'd0) || (in.addr_low == lamt_pkg::NULL_V4LO));
  end

  assign in.ready = (count != 2'd2);
  assign push     = in.valid && in.ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: rtl/lamt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamt_back
// Address compare, link row read and update sequencer with result register.
// ----------------------------------------------------------------------------
module lamt_back #(
  parameter int TABLE_ENTRIES   = lamt_pkg::TABLE_ENTRIES_DEF,
  parameter int LINKS_PER_ENTRY = lamt_pkg::LINKS_PER_ENTRY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  lamt_pkg::work_t q_item,
  input  logic            q_valid,
  output logic            q_pop,
  lamt_out_if.source      out
);

  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int L  = LINKS_PER_ENTRY;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_EXE  = 2'd3;

  typedef struct packed {
    logic [1:0]                  kind;
    lamt_pkg::slot_t [L-1:0]     slots;
  } row_t;

  logic [1:0]             state;
  lamt_pkg::work_t        cur;
  logic [TABLE_ENTRIES-1:0] entry_used;
  logic [63:0]            addr_hi [TABLE_ENTRIES];
  logic [63:0]            addr_lo [TABLE_ENTRIES];
  logic [L-1:0]           slot_used [TABLE_ENTRIES];
  row_t                   row_mem [TABLE_ENTRIES];
  row_t                   row_q;
  logic                   accept_any;

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] orphan_vec;
  logic                   hit_c, free_c;
  logic [EW-1:0]          hit_idx_c, free_idx_c;
  logic                   hit, free_ok;
  logic [EW-1:0]          hit_idx, free_idx, ent_idx;

  logic [L-1:0]           used, used_new, own_hit, own_sel, free_sel;
  logic                   own_any, free_any;
  row_t                   row_new;
  logic                   row_wr, ent_set, ent_clr, any_set, any_clr;
  logic [1:0]             r_status, r_match;
  logic                   r_added, r_ldrop, r_edrop;
  logic                   out_free, commit;
  logic [15:0]            dec_refs;

  // parallel compare and lowest-index encoders
  always_comb begin
    hit_c      = 1'b0;
    free_c     = 1'b0;
    hit_idx_c  = '0;
    free_idx_c = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i]    = entry_used[i] && (addr_hi[i] == cur.hi) && (addr_lo[i] == cur.lo);
      orphan_vec[i] = entry_used[i] && (slot_used[i] == '0);
    end
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = EW'(i);
      end
      if (!entry_used[i]) begin
        free_c     = 1'b1;
        free_idx_c = EW'(i);
      end
    end
  end

  // link slot selection
  always_comb begin
    own_any  = 1'b0;
    free_any = 1'b0;
    own_sel  = '0;
    free_sel = '0;
    used     = slot_used[ent_idx];
    for (int k = 0; k < L; k++) begin
      own_hit[k] = used[k] && (row_q.slots[k].owner == cur.owner);
      if (own_hit[k] && !own_any) begin
        own_sel[k] = 1'b1;
        own_any    = 1'b1;
      end
      if (!used[k] && !free_any) begin
        free_sel[k] = 1'b1;
        free_any    = 1'b1;
      end
    end
  end

  always_comb begin
    row_new  = row_q;
    used_new = used;
    row_wr   = 1'b0;
    ent_set  = 1'b0;
    ent_clr  = 1'b0;
    any_set  = 1'b0;
    any_clr  = 1'b0;
    r_status = lamt_pkg::STATUS_OK;
    r_match  = lamt_pkg::KIND_NONE;
    r_added  = 1'b0;
    r_ldrop  = 1'b0;
    r_edrop  = 1'b0;
    dec_refs = '0;
    case (cur.cmd)
      lamt_pkg::CMD_INSERT: begin
        if (!cur.owner_ok) begin
          r_status = lamt_pkg::STATUS_NOT_FOUND;
        end else if (!hit && !free_ok) begin
          r_status = lamt_pkg::STATUS_TABLE_FULL;
        end else begin
          if (hit && own_any) begin
            row_wr = 1'b1;
            for (int k = 0; k < L; k++) begin
              if (own_sel[k] && row_q.slots[k].refs != lamt_pkg::REFS_MAX) begin
                row_new.slots[k].refs = row_q.slots[k].refs + 16'd1;
              end
            end
          end else if (free_any) begin
            row_wr  = 1'b1;
            r_added = 1'b1;
            for (int k = 0; k < L; k++) begin
              if (free_sel[k]) begin
                used_new[k]            = 1'b1;
                row_new.slots[k].owner = cur.owner;
                row_new.slots[k].refs  = 16'd1;
              end
            end
          end else begin
            r_status = lamt_pkg::STATUS_LINKS_FULL;
          end
          if (!hit) begin
            ent_set      = 1'b1;
            row_new.kind = cur.kind;
            any_set      = cur.null_addr;
          end
        end
      end
      lamt_pkg::CMD_REMOVE: begin
        if (!cur.owner_ok || !hit || !own_any) begin
          r_status = lamt_pkg::STATUS_NOT_FOUND;
        end else begin
          row_wr = 1'b1;
          for (int k = 0; k < L; k++) begin
            if (own_sel[k]) begin
              dec_refs = (row_q.slots[k].refs == 16'd0) ? 16'd0
                                                        : row_q.slots[k].refs - 16'd1;
              row_new.slots[k].refs = dec_refs;
              if (dec_refs == 16'd0) begin
                used_new[k] = 1'b0;
                r_ldrop     = 1'b1;
              end
            end
          end
          if (r_ldrop && used_new == '0) begin
            ent_clr = 1'b1;
            r_edrop = 1'b1;
            any_clr = cur.null_addr;
          end
        end
      end
      lamt_pkg::CMD_LOOKUP: begin
        if (hit) begin
          r_match = row_q.kind;
        end else if (accept_any) begin
          r_match = lamt_pkg::KIND_UNICAST;
        end
        r_status = (r_match != lamt_pkg::KIND_NONE) ? lamt_pkg::STATUS_OK
                                                    : lamt_pkg::STATUS_NOT_FOUND;
      end
      default: begin
        r_status = lamt_pkg::STATUS_OK;
      end
    endcase
  end

  assign out_free = !out.valid || out.ready;
  assign commit   = (state == ST_EXE) && out_free;
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == ST_CMP) begin
      hit      <= hit_c;
      hit_idx  <= hit_idx_c;
      free_ok  <= free_c;
      free_idx <= free_idx_c;
    end
    if (state == ST_RD) begin
      ent_idx <= hit ? hit_idx : free_idx;
      row_q   <= row_mem[hit ? hit_idx : free_idx];
    end
    if (commit && row_wr) begin
      row_mem[ent_idx] <= row_new;
    end
    if (commit && ent_set) begin
      addr_hi[ent_idx] <= cur.hi;
      addr_lo[ent_idx] <= cur.lo;
    end
    if (commit) begin
      out.status        <= r_status;
      out.match_kind    <= r_match;
      out.link_added    <= r_added;
      out.link_dropped  <= r_ldrop;
      out.entry_dropped <= r_edrop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      entry_used <= '0;
      accept_any <= 1'b0;
      out.valid  <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_used[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_CMP;
          end
        end
        ST_CMP:  state <= ST_RD;
        ST_RD:   state <= ST_EXE;
        ST_EXE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (commit) begin
        slot_used[ent_idx] <= used_new;
        if (ent_set) begin
          entry_used[ent_idx] <= 1'b1;
        end
        if (ent_clr) begin
          entry_used[ent_idx] <= 1'b0;
        end
        if (any_set) begin
          accept_any <= 1'b1;
        end
        if (any_clr) begin
          accept_any <= 1'b0;
        end
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> $onehot0(hit_vec))
    else $error("address present in more than one entry");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> orphan_vec == '0)
    else $error("used entry without any link");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out.valid) |-> $past(state) == ST_EXE)
    else $error("result beat not from update step");

  a_edrop_ldrop: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.entry_dropped |-> out.link_dropped)
    else $error("entry freed without dropping a link");

endmodule

FILE: rtl/local_address_match_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_address_match_table
// Reference-counted table of local addresses with links to logical interfaces.
// ----------------------------------------------------------------------------
// Each request beat (insert, remove or lookup) yields one result beat. The
// front queues up to two requests; the back handles one at a time in order:
// queue pop, parallel compare of the address against every entry, link row
// read from the row memory, then update and result. The row memory read port
// and the compare make these separate steps. A result waiting in the output
// register does not block the front from taking new requests until its
// two-deep queue is full.
module local_address_match_table #(
  parameter int TABLE_ENTRIES   = lamt_pkg::TABLE_ENTRIES_DEF,
  parameter int LINKS_PER_ENTRY = lamt_pkg::LINKS_PER_ENTRY_DEF,
  parameter int LOGICAL_IFCS    = lamt_pkg::LOGICAL_IFCS_DEF
) (
  input logic        clk,
  input logic        rst,
  lamt_in_if.sink    in,
  lamt_out_if.source out
);

  lamt_pkg::work_t q_item;
  logic            q_valid;
  logic            q_pop;

  lamt_front #(
    .LOGICAL_IFCS (LOGICAL_IFCS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in      (in),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  lamt_back #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .LINKS_PER_ENTRY (LINKS_PER_ENTRY)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out     (out)
  );

endmodule

FILE: bench/tb_local_address_match_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_local_address_match_table
// Drives insert, remove and lookup beats into the address table with random
// gaps and output stalls, predicts every result from a local copy of the
// table and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_local_address_match_table;

  localparam int NENT = lamt_pkg::TABLE_ENTRIES_DEF;
  localparam int NLNK = lamt_pkg::LINKS_PER_ENTRY_DEF;
  localparam int NIFC = lamt_pkg::LOGICAL_IFCS_DEF;
  localparam int NSLOT = NENT * NLNK;
  localparam int WDOG_LIMIT = 20000;
  localparam logic [1:0] CMD_BAD = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] match_kind;
    logic       link_added;
    logic       link_dropped;
    logic       entry_dropped;
  } res_t;

  class addr_table_scoreboard;
    bit          ent_used [NENT];
    logic [63:0] ent_hi [NENT];
    logic [63:0] ent_lo [NENT];
    logic [1:0]  ent_kind [NENT];
    bit          lnk_used [NSLOT];
    logic [3:0]  lnk_owner [NSLOT];
    logic [15:0] lnk_refs [NSLOT];
    bit          any_addr;
    res_t        pending [$];
    int          errors;

    function int find_ent(logic [63:0] hi, logic [63:0] lo);
      for (int e = 0; e < NENT; e++)
        if (ent_used[e] && ent_hi[e] == hi && ent_lo[e] == lo) return e;
      return -1;
    endfunction

    function int find_lnk(int e, logic [3:0] ow);
      for (int k = 0; k < NLNK; k++)
        if (lnk_used[e*NLNK+k] && lnk_owner[e*NLNK+k] == ow) return e*NLNK+k;
      return -1;
    endfunction

    function bit is_null(logic [63:0] hi, logic [63:0] lo);
      return hi == 0 && (lo == 0 || lo == lamt_pkg::NULL_V4LO);
    endfunction

    function void note_request(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
                               logic [1:0] kind, logic [3:0] ow);
      res_t r;
      int e, s, k;
      r = '0;
      if (cmd == lamt_pkg::CMD_INSERT) begin
        if (int'(ow) >= NIFC) r.status = lamt_pkg::STATUS_NOT_FOUND;
        else begin
          e = find_ent(hi, lo);
          if (e < 0) begin
            for (k = 0; k < NENT; k++) if (!ent_used[k]) break;
            if (k == NENT) r.status = lamt_pkg::STATUS_TABLE_FULL;
            else begin
              e = k;
              ent_used[e] = 1; ent_hi[e] = hi; ent_lo[e] = lo;
              ent_kind[e] = (kind == lamt_pkg::KIND_NONE) ? lamt_pkg::KIND_UNICAST : kind;
              if (is_null(hi, lo)) any_addr = 1;
            end
          end
          if (e >= 0) begin
            s = find_lnk(e, ow);
            if (s >= 0) begin
              if (lnk_refs[s] != lamt_pkg::REFS_MAX) lnk_refs[s]++;
            end else begin
              for (k = 0; k < NLNK; k++) if (!lnk_used[e*NLNK+k]) break;
              if (k == NLNK) r.status = lamt_pkg::STATUS_LINKS_FULL;
              else begin
                s = e*NLNK+k;
                lnk_used[s] = 1; lnk_owner[s] = ow; lnk_refs[s] = 1;
                r.link_added = 1;
              end
            end
          end
        end
      end else if (cmd == lamt_pkg::CMD_REMOVE) begin
        e = (int'(ow) < NIFC) ? find_ent(hi, lo) : -1;
        s = (e >= 0) ? find_lnk(e, ow) : -1;
        if (s < 0) r.status = lamt_pkg::STATUS_NOT_FOUND;
        else begin
          if (lnk_refs[s] != 0) lnk_refs[s]--;
          if (lnk_refs[s] == 0) begin
            lnk_used[s] = 0;
            r.link_dropped = 1;
            for (k = 0; k < NLNK; k++) if (lnk_used[e*NLNK+k]) break;
            if (k == NLNK) begin
              ent_used[e] = 0;
              r.entry_dropped = 1;
              if (is_null(hi, lo)) any_addr = 0;
            end
          end
        end
      end else if (cmd == lamt_pkg::CMD_LOOKUP) begin
        e = find_ent(hi, lo);
        if (e >= 0) r.match_kind = ent_kind[e];
        else if (any_addr) r.match_kind = lamt_pkg::KIND_UNICAST;
        r.status = (r.match_kind != lamt_pkg::KIND_NONE) ? lamt_pkg::STATUS_OK
                                                          : lamt_pkg::STATUS_NOT_FOUND;
      end
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t x;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      x = pending.pop_front();
      if (got.status !== x.status) begin
        $error("status exp %0d got %0d", x.status, got.status); errors++;
      end
      if (got.match_kind !== x.match_kind) begin
        $error("match_kind exp %0d got %0d", x.match_kind, got.match_kind); errors++;
      end
      if (got.link_added !== x.link_added) begin
        $error("link_added exp %0d got %0d", x.link_added, got.link_added); errors++;
      end
      if (got.link_dropped !== x.link_dropped) begin
        $error("link_dropped exp %0d got %0d", x.link_dropped, got.link_dropped);
        errors++;
      end
      if (got.entry_dropped !== x.entry_dropped) begin
        $error("entry_dropped exp %0d got %0d", x.entry_dropped, got.entry_dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  lamt_in_if  req_ch ();
  lamt_out_if res_ch ();
  addr_table_scoreboard sb;
  int idle_cycles;
  bit long_hold;
  logic [63:0] pool_hi [24];
  logic [63:0] pool_lo [24];

  local_address_match_table DUT (
    .clk(clk),
    .rst(rst),
    .in (req_ch.sink),
    .out(res_ch.source)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    req_ch.valid = 0;
    req_ch.command = lamt_pkg::CMD_INSERT;
    req_ch.addr_high = '0;
    req_ch.addr_low = '0;
    req_ch.entry_kind = lamt_pkg::KIND_UNICAST;
    req_ch.lifc_id = '0;
    res_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.command, req_ch.addr_high, req_ch.addr_low,
                        req_ch.entry_kind, req_ch.lifc_id);
      if (res_ch.valid && res_ch.ready)
        sb.check_result({res_ch.status, res_ch.match_kind, res_ch.link_added,
                         res_ch.link_dropped, res_ch.entry_dropped});
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold when asked
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        res_ch.ready <= 0;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end
      w = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w == 0) begin
        res_ch.ready <= 1;
        @(negedge clk);
        while (!(res_ch.valid === 1'b1)) @(negedge clk);
      end else begin
        res_ch.ready <= 0;
        repeat (w) @(negedge clk);
        res_ch.ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_beat(logic [1:0] cmd, logic [63:0] hi, logic [63:0] lo,
                           logic [1:0] kind, logic [3:0] ow, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 13) : 0;
    if (gaps && $urandom_range(0, 2) == 0) w = 0;
    if (w > 0) begin
      req_ch.valid <= 0;
      repeat (w) @(negedge clk);
    end
    req_ch.valid <= 1;
    req_ch.command <= cmd;
    req_ch.addr_high <= hi;
    req_ch.addr_low <= lo;
    req_ch.entry_kind <= kind;
    req_ch.lifc_id <= ow;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_all();
    req_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(bit gaps);
    logic [1:0] cmd;
    logic [63:0] hi, lo;
    int p, r;
    r = $urandom_range(0, 99);
    cmd = (r < 45) ? lamt_pkg::CMD_INSERT : (r < 75) ? lamt_pkg::CMD_REMOVE :
          (r < 97) ? lamt_pkg::CMD_LOOKUP : CMD_BAD;
    p = $urandom_range(0, 23);
    hi = pool_hi[p];
    lo = pool_lo[p];
    if ($urandom_range(0, 9) == 0) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
    end
    send_beat(cmd, hi, lo, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), gaps);
  endtask

  initial begin
    sb = new();
    idle_cycles = 0;
    long_hold = 0;
    for (int i = 0; i < 24; i++) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, $urandom};
    end
    pool_hi[0] = '0; pool_lo[0] = '0;
    pool_hi[1] = '0; pool_lo[1] = lamt_pkg::NULL_V4LO;
    pool_hi[2] = '1; pool_lo[2] = '1;
    repeat (4) @(negedge clk);
    rst = 0;

    // directed
    send_beat(lamt_pkg::CMD_LOOKUP, '1, '1, 2'd1, 4'd0, 0);
    send_beat(CMD_BAD, '1, '1, 2'd3, 4'hf, 0);
    send_beat(lamt_pkg::CMD_REMOVE, '1, '1, 2'd1, 4'd0, 0);
    send_beat(lamt_pkg::CMD_INSERT, '1, '1, 2'd0, 4'hf, 0);
    send_beat(lamt_pkg::CMD_INSERT, '1, '1, 2'd3, 4'hf, 0);
    send_beat(lamt_pkg::CMD_LOOKUP, '1, '1, 2'd2, 4'd0, 0);
    for (int k = 0; k < 4; k++) send_beat(lamt_pkg::CMD_INSERT, '1, '1, 2'd2, 4'(k), 0);
    send_beat(lamt_pkg::CMD_REMOVE, '1, '1, 2'd1, 4'd9, 0);
    send_beat(lamt_pkg::CMD_INSERT, '0, '0, 2'd2, 4'd1, 0);
    send_beat(lamt_pkg::CMD_LOOKUP, 64'h5, 64'h7, 2'd1, 4'd1, 0);
    send_beat(lamt_pkg::CMD_REMOVE, '0, '0, 2'd2, 4'd1, 0);
    send_beat(lamt_pkg::CMD_LOOKUP, 64'h5, 64'h7, 2'd1, 4'd1, 0);
    send_beat(lamt_pkg::CMD_INSERT, '0, lamt_pkg::NULL_V4LO, 2'd3, 4'd2, 0);
    send_beat(lamt_pkg::CMD_LOOKUP, '0, '0, 2'd1, 4'd1, 0);
    send_beat(lamt_pkg::CMD_REMOVE, '0, lamt_pkg::NULL_V4LO, 2'd3, 4'd2, 0);
    for (int k = 0; k < 4; k++) send_beat(lamt_pkg::CMD_REMOVE, '1, '1, 2'd2, 4'(k), 0);
    for (int k = 0; k < 2; k++) send_beat(lamt_pkg::CMD_REMOVE, '1, '1, 2'd2, 4'hf, 0);
    drain_all();

    // fill the table and try one more
    for (int e = 0; e < NENT; e++)
      send_beat(lamt_pkg::CMD_INSERT, 64'hA000 + e, 64'(e), 2'(1 + e % 3), 4'(e % 16), 1);
    send_beat(lamt_pkg::CMD_INSERT, 64'hBEEF, 64'h1, 2'd1, 4'd0, 1);
    for (int e = 0; e < NENT; e++)
      send_beat(lamt_pkg::CMD_REMOVE, 64'hA000 + e, 64'(e), 2'd1, 4'(e % 16), 1);
    drain_all();

    // random, with a long output hold partway
    for (int n = 0; n < 1000; n++) begin
      if (n == 400) long_hold = 1;
      send_random(n >= 400 && n < 460 ? 0 : 1);
      if (n == 800) drain_all();
    end
    drain_all();
    repeat (40) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lamt_pkg.sv
rtl/lamt_if.sv
rtl/lamt_front.sv
rtl/lamt_back.sv
rtl/local_address_match_table.sv
bench/tb_local_address_match_table.sv
